// ===== hw/rtl/ucc_pkg.sv =====
`default_nettype none

package ucc_pkg;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } ucc_action_e;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned LenWidth = 3;

  localparam logic [LenWidth-1:0] LenNone = 3'd0;
  localparam logic [LenWidth-1:0] LenMax  = 3'd6;

  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] ContMask = 8'hc0;

  typedef struct packed {
    ucc_action_e         action;
    logic [CpWidth-1:0]  code_point_in;
    logic [LenWidth-1:0] avail;
    logic [7:0]          in_byte0;
    logic [7:0]          in_byte1;
    logic [7:0]          in_byte2;
    logic [7:0]          in_byte3;
    logic [7:0]          in_byte4;
    logic [7:0]          in_byte5;
  } ucc_cmd_t;

  typedef struct packed {
    logic [LenWidth-1:0] seq_length;
    logic [CpWidth-1:0]  code_point_out;
    logic [7:0]          out_byte0;
    logic [7:0]          out_byte1;
    logic [7:0]          out_byte2;
    logic [7:0]          out_byte3;
    logic [7:0]          out_byte4;
    logic [7:0]          out_byte5;
  } ucc_res_t;

  // Clamp the byte count: 6 and 7 both mean six or more.
  function automatic logic [LenWidth-1:0] clamp_room(input logic [LenWidth-1:0] avail);
    logic [LenWidth-1:0] room;
    room = (avail > LenMax) ? LenMax : avail;
    return room;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_codepoint_codec_top.sv =====
`default_nettype none
// Result path: a command taken at a clock edge is held in cmd_q, and its result then in res_q;
//   done_o is high for the one cycle that follows the first edge after the transfer.
// Throughput: one command per cycle; busy stays low, the register pair
//   (command register, result register) holds one command each.
// Reset: rst_ni clears the valid flags of both registers; no result is lost to stall,
//   since the receiver cannot stall.
module utf8_codepoint_codec_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ucc_pkg::ucc_cmd_t cmd_i,
  output logic              done_o,
  output ucc_pkg::ucc_res_t result_o
);
  import ucc_pkg::*;

  ucc_cmd_t cmd_q;
  logic     vld_q;
  ucc_res_t enc_res;
  ucc_res_t dec_res;
  ucc_res_t res_d;
  ucc_res_t res_q;
  logic     done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  ucc_encoder u_enc (
    .cmd_i (cmd_q),
    .res_o (enc_res)
  );

  ucc_decoder u_dec (
    .cmd_i (cmd_q),
    .res_o (dec_res)
  );

  always_comb begin
    unique case (cmd_q.action)
      ACT_ENCODE: res_d = enc_res;
      default:    res_d = dec_res;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ucc_encoder.sv =====
`default_nettype none

module ucc_encoder (
  input  ucc_pkg::ucc_cmd_t cmd_i,
  output ucc_pkg::ucc_res_t res_o
);
  import ucc_pkg::*;

  logic [CpWidth-1:0]  cp;
  logic [LenWidth-1:0] len;
  logic [LenWidth-1:0] room;

  assign cp   = cmd_i.code_point_in;
  assign room = clamp_room(cmd_i.avail);

  always_comb begin
    priority if (cp <= 31'h0000007f) begin
      len = 3'd1;
    end else if (cp <= 31'h000007ff) begin
      len = 3'd2;
    end else if (cp <= 31'h0000ffff) begin
      len = 3'd3;
    end else if (cp <= 31'h001fffff) begin
      len = 3'd4;
    end else if (cp <= 31'h03ffffff) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
  end

  always_comb begin
    res_o = '0;
    if (len <= room) begin
      res_o.seq_length = len;
      unique case (len)
        3'd1: begin
          res_o.out_byte0 = {1'b0, cp[6:0]};
        end
        3'd2: begin
          res_o.out_byte0 = {3'b110, cp[10:6]};
          res_o.out_byte1 = {2'b10, cp[5:0]};
        end
        3'd3: begin
          res_o.out_byte0 = {4'b1110, cp[15:12]};
          res_o.out_byte1 = {2'b10, cp[11:6]};
          res_o.out_byte2 = {2'b10, cp[5:0]};
        end
        3'd4: begin
          res_o.out_byte0 = {5'b11110, cp[20:18]};
          res_o.out_byte1 = {2'b10, cp[17:12]};
          res_o.out_byte2 = {2'b10, cp[11:6]};
          res_o.out_byte3 = {2'b10, cp[5:0]};
        end
        3'd5: begin
          res_o.out_byte0 = {6'b111110, cp[25:24]};
          res_o.out_byte1 = {2'b10, cp[23:18]};
          res_o.out_byte2 = {2'b10, cp[17:12]};
          res_o.out_byte3 = {2'b10, cp[11:6]};
          res_o.out_byte4 = {2'b10, cp[5:0]};
        end
        default: begin
          res_o.out_byte0 = {7'b1111110, cp[30]};
          res_o.out_byte1 = {2'b10, cp[29:24]};
          res_o.out_byte2 = {2'b10, cp[23:18]};
          res_o.out_byte3 = {2'b10, cp[17:12]};
          res_o.out_byte4 = {2'b10, cp[11:6]};
          res_o.out_byte5 = {2'b10, cp[5:0]};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucc_decoder.sv =====
`default_nettype none

module ucc_decoder (
  input  ucc_pkg::ucc_cmd_t cmd_i,
  output ucc_pkg::ucc_res_t res_o
);
  import ucc_pkg::*;

  logic [7:0]          b0;
  logic [LenWidth-1:0] len;
  logic [LenWidth-1:0] room;
  logic [5:1]          is_cont;
  logic                cont_ok;

  assign b0   = cmd_i.in_byte0;
  assign room = clamp_room(cmd_i.avail);

  assign is_cont[1] = (cmd_i.in_byte1 & ContMask) == ContTag;
  assign is_cont[2] = (cmd_i.in_byte2 & ContMask) == ContTag;
  assign is_cont[3] = (cmd_i.in_byte3 & ContMask) == ContTag;
  assign is_cont[4] = (cmd_i.in_byte4 & ContMask) == ContTag;
  assign is_cont[5] = (cmd_i.in_byte5 & ContMask) == ContTag;

  always_comb begin
    priority if (b0[7] == 1'b0) begin
      len = 3'd1;
    end else if (b0[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b0[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b0[7:3] == 5'b11110) begin
      len = 3'd4;
    end else if (b0[7:2] == 6'b111110) begin
      len = 3'd5;
    end else if (b0[7:1] == 7'b1111110) begin
      len = 3'd6;
    end else begin
      len = LenNone;
    end
  end

  // Only bytes inside the sequence must carry the continuation tag.
  always_comb begin
    unique case (len)
      3'd1:    cont_ok = 1'b1;
      3'd2:    cont_ok = is_cont[1];
      3'd3:    cont_ok = &is_cont[2:1];
      3'd4:    cont_ok = &is_cont[3:1];
      3'd5:    cont_ok = &is_cont[4:1];
      3'd6:    cont_ok = &is_cont[5:1];
      default: cont_ok = 1'b0;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (len != LenNone && len <= room && cont_ok) begin
      res_o.seq_length = len;
      unique case (len)
        3'd1: res_o.code_point_out = {24'd0, b0[6:0]};
        3'd2: res_o.code_point_out = {20'd0, b0[4:0], cmd_i.in_byte1[5:0]};
        3'd3: res_o.code_point_out = {15'd0, b0[3:0], cmd_i.in_byte1[5:0],
                                      cmd_i.in_byte2[5:0]};
        3'd4: res_o.code_point_out = {10'd0, b0[2:0], cmd_i.in_byte1[5:0],
                                      cmd_i.in_byte2[5:0], cmd_i.in_byte3[5:0]};
        3'd5: res_o.code_point_out = {5'd0, b0[1:0], cmd_i.in_byte1[5:0],
                                      cmd_i.in_byte2[5:0], cmd_i.in_byte3[5:0],
                                      cmd_i.in_byte4[5:0]};
        default: res_o.code_point_out = {b0[0], cmd_i.in_byte1[5:0],
                                         cmd_i.in_byte2[5:0], cmd_i.in_byte3[5:0],
                                         cmd_i.in_byte4[5:0], cmd_i.in_byte5[5:0]};
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucc_checker.sv =====
`default_nettype none

module ucc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input ucc_pkg::ucc_res_t result_o
);
  import ucc_pkg::*;

  // Every taken command produces a result once the command and result registers are loaded.
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("taken command produced no result");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a command");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.seq_length <= LenMax)
    else $error("sequence length out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.seq_length == LenNone |->
      result_o.code_point_out == '0 && result_o.out_byte0 == '0)
    else $error("failed transfer carries data");

  a_decode_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.code_point_out != '0 |->
      result_o.out_byte0 == '0 && result_o.out_byte1 == '0 &&
      result_o.out_byte5 == '0)
    else $error("decode result carries encoded bytes");

endmodule

bind utf8_codepoint_codec_top ucc_checker u_ucc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

// ===== bench/tb_utf8_codepoint_codec_top.sv =====
`default_nettype none

module tb_utf8_codepoint_codec_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucc_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ucc_cmd_t cmd = '0;
  logic     done;
  ucc_res_t result;

  ucc_cmd_t    cmds_to_send[$];
  ucc_res_t    results_due[$];
  int unsigned cmds_queued = 0;
  int unsigned cmds_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  logic        xfer_taken = 1'b0;
  ucc_res_t    want;

  utf8_codepoint_codec_top i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done),
    .result_o(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, want_v));
    end
  endtask

  // Encode or decode one code point, original six-byte form.
  function automatic ucc_res_t utf8_transcode(ucc_cmd_t c);
    ucc_res_t    r;
    logic [7:0]  ib[6];
    logic [7:0]  ob[6];
    logic [7:0]  prefix;
    logic [7:0]  lead_mask;
    int unsigned room;
    int unsigned n;
    int unsigned cp;
    bit          ok;

    r = '0;
    ob = '{default: 8'h00};
    ib = '{c.in_byte0, c.in_byte1, c.in_byte2, c.in_byte3, c.in_byte4, c.in_byte5};
    room = (c.avail > LenMax) ? 32'(LenMax) : 32'(c.avail);

    if (c.action == ACT_ENCODE) begin
      cp = 32'(c.code_point_in);
      if (cp <= 32'h7f)            n = 1;
      else if (cp <= 32'h7ff)      n = 2;
      else if (cp <= 32'hffff)     n = 3;
      else if (cp <= 32'h1fffff)   n = 4;
      else if (cp <= 32'h3ffffff)  n = 5;
      else                         n = 6;
      case (n)
        1:       prefix = 8'h00;
        2:       prefix = 8'hc0;
        3:       prefix = 8'he0;
        4:       prefix = 8'hf0;
        5:       prefix = 8'hf8;
        default: prefix = 8'hfc;
      endcase
      if (n <= room) begin
        r.seq_length = n[LenWidth-1:0];
        ob[0] = prefix | 8'(cp >> (6 * (n - 1)));
        for (int k = 1; k < n; k++) begin
          ob[k] = ContTag | (8'(cp >> (6 * (n - 1 - k))) & 8'h3f);
        end
      end
    end else begin
      casez (ib[0])
        8'b0???????: begin n = 1; lead_mask = 8'h7f; end
        8'b110?????: begin n = 2; lead_mask = 8'h1f; end
        8'b1110????: begin n = 3; lead_mask = 8'h0f; end
        8'b11110???: begin n = 4; lead_mask = 8'h07; end
        8'b111110??: begin n = 5; lead_mask = 8'h03; end
        8'b1111110?: begin n = 6; lead_mask = 8'h01; end
        default:     begin n = 0; lead_mask = 8'h00; end
      endcase
      ok = (n != 0) && (n <= room);
      for (int k = 1; k < 6; k++) begin
        if (k < n && (ib[k] & ContMask) != ContTag) ok = 1'b0;
      end
      if (ok) begin
        cp = 32'(ib[0] & lead_mask);
        for (int k = 1; k < n; k++) cp = (cp << 6) | 32'(ib[k] & 8'h3f);
        r.seq_length     = n[LenWidth-1:0];
        r.code_point_out = cp[CpWidth-1:0];
      end
    end

    r.out_byte0 = ob[0];
    r.out_byte1 = ob[1];
    r.out_byte2 = ob[2];
    r.out_byte3 = ob[3];
    r.out_byte4 = ob[4];
    r.out_byte5 = ob[5];
    return r;
  endfunction

  function automatic ucc_cmd_t make_cmd(ucc_action_e act, logic [CpWidth-1:0] cp,
                                        logic [LenWidth-1:0] av, logic [47:0] seq);
    ucc_cmd_t c;
    c.action        = act;
    c.code_point_in = cp;
    c.avail         = av;
    c.in_byte0      = seq[47:40];
    c.in_byte1      = seq[39:32];
    c.in_byte2      = seq[31:24];
    c.in_byte3      = seq[23:16];
    c.in_byte4      = seq[15:8];
    c.in_byte5      = seq[7:0];
    return c;
  endfunction

  // Pick a length class first so long sequences are as common as short ones.
  function automatic logic [CpWidth-1:0] random_code_point();
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(5))
      0:       begin lo = 32'h0;       hi = 32'h7f;       end
      1:       begin lo = 32'h80;      hi = 32'h7ff;      end
      2:       begin lo = 32'h800;     hi = 32'hffff;     end
      3:       begin lo = 32'h10000;   hi = 32'h1fffff;   end
      4:       begin lo = 32'h200000;  hi = 32'h3ffffff;  end
      default: begin lo = 32'h4000000; hi = 32'h7fffffff; end
    endcase
    return CpWidth'($urandom_range(hi, lo));
  endfunction

  function automatic ucc_cmd_t random_cmd();
    ucc_cmd_t    c;
    ucc_res_t    enc;
    logic [7:0]  seq[6];
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    logic [1:0]  top;

    c.action        = ACT_DECODE;
    c.code_point_in = CpWidth'($urandom);
    c.avail         = LenWidth'($urandom_range(7));
    for (int i = 0; i < 6; i++) seq[i] = 8'($urandom);
    kind = $urandom_range(99);

    if (kind < 35) begin
      c.action        = ACT_ENCODE;
      c.code_point_in = random_code_point();
      if ($urandom_range(99) < 60) c.avail = LenWidth'($urandom_range(7, 6));
    end else if (kind < 88) begin
      // well-formed sequence built by the encoder, random tail past its end
      enc = utf8_transcode(make_cmd(ACT_ENCODE, random_code_point(), LenMax, 48'h0));
      n = 32'(enc.seq_length);
      seq[0] = enc.out_byte0;
      if (n > 1) seq[1] = enc.out_byte1;
      if (n > 2) seq[2] = enc.out_byte2;
      if (n > 3) seq[3] = enc.out_byte3;
      if (n > 4) seq[4] = enc.out_byte4;
      if (n > 5) seq[5] = enc.out_byte5;
      if ($urandom_range(99) < 75) c.avail = LenWidth'($urandom_range(7, n));
      // break one continuation byte
      if (kind >= 76 && n > 1) begin
        k = $urandom_range(n - 1, 1);
        top = 2'($urandom_range(2));
        if (top == 2'b10) top = 2'b11;
        seq[k] = {top, seq[k][5:0]};
      end
    end

    c.in_byte0 = seq[0];
    c.in_byte1 = seq[1];
    c.in_byte2 = seq[2];
    c.in_byte3 = seq[3];
    c.in_byte4 = seq[4];
    c.in_byte5 = seq[5];
    return c;
  endfunction

  task automatic queue_cmd(ucc_cmd_t c);
    cmds_to_send.push_back(c);
    cmds_queued++;
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_queued || results_due.size() != 0) @(negedge clk);
  endtask

  // Sample at the rising edge: check results, record accepted commands.
  always @(posedge clk) begin
    xfer_taken = 1'b0;
    if (rst_n) begin
      if (done) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("seq_length", 32'(result.seq_length), 32'(want.seq_length));
          check_field("code_point_out", 32'(result.code_point_out), 32'(want.code_point_out));
          check_field("out_byte0", 32'(result.out_byte0), 32'(want.out_byte0));
          check_field("out_byte1", 32'(result.out_byte1), 32'(want.out_byte1));
          check_field("out_byte2", 32'(result.out_byte2), 32'(want.out_byte2));
          check_field("out_byte3", 32'(result.out_byte3), 32'(want.out_byte3));
          check_field("out_byte4", 32'(result.out_byte4), 32'(want.out_byte4));
          check_field("out_byte5", 32'(result.out_byte5), 32'(want.out_byte5));
        end
      end
      if (start && !busy) begin
        results_due.push_back(utf8_transcode(cmd));
        cmds_taken++;
        xfer_taken = 1'b1;
      end
    end
  end

  // Drive at the falling edge; hold the command until its transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || xfer_taken) begin
      if (cmds_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd   <= cmds_to_send.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned phase_pct[3];

    phase_pct = '{0, 45, 28};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 0;
    queue_cmd(make_cmd(ACT_ENCODE, 31'h0,        3'd6, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h7f,       3'd1, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h80,       3'd7, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h7ff,      3'd2, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h800,      3'd6, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'hffff,     3'd3, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h10000,    3'd7, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h1fffff,   3'd4, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h200000,   3'd6, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h3ffffff,  3'd5, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h4000000,  3'd7, 48'hffffffffffff));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h7fffffff, 3'd6, 48'h0));
    // no room
    queue_cmd(make_cmd(ACT_ENCODE, 31'h7fffffff, 3'd5, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h80,       3'd1, 48'h0));
    queue_cmd(make_cmd(ACT_ENCODE, 31'h0,        3'd0, 48'h0));
    // decode: nothing present, ASCII, bad leads, longest form
    queue_cmd(make_cmd(ACT_DECODE, 31'h7fffffff, 3'd0, 48'h410000000000));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd1, 48'h00ffffffffff));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd6, 48'h808080808080));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd6, 48'hfebfbfbfbfbf));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd7, 48'hffbfbfbfbfbf));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd7, 48'hfdbfbfbfbfbf));
    // bad continuation, truncated, overlong, surrogate
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd3, 48'he28241000000));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd2, 48'he282ac000000));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd2, 48'hc08000000000));
    queue_cmd(make_cmd(ACT_DECODE, 31'h0,        3'd3, 48'heda080000000));
    wait_drained();

    // sender holds off between phases until every result is back
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (150) queue_cmd(random_cmd());
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("tb_utf8_codepoint_codec_top: PASS");
    end else begin
      $display("tb_utf8_codepoint_codec_top: FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_utf8_codepoint_codec_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== utf8_codepoint_codec_top.f =====
hw/rtl/ucc_pkg.sv
hw/rtl/ucc_encoder.sv
hw/rtl/ucc_decoder.sv
hw/rtl/utf8_codepoint_codec_top.sv
hw/rtl/ucc_checker.sv
bench/tb_utf8_codepoint_codec_top.sv
